// File: rtl/utft_pkg.sv
// Shared types, constants and helper functions for the UTF transcoder.
// Used by the front, queue, back and top-level modules; no dependencies.
package utft_pkg;

  localparam logic [1:0] FMT_UTF8  = 2'd0;
  localparam logic [1:0] FMT_UTF16 = 2'd1;
  localparam logic [1:0] FMT_UTF32 = 2'd2;

  localparam logic [1:0] CFG_SOURCE_FORMAT    = 2'd0;
  localparam logic [1:0] CFG_TARGET_FORMAT    = 2'd1;
  localparam logic [1:0] CFG_REPLACEMENT_CODE = 2'd2;

  localparam int QDEPTH = 4;

  // One work item from front to back: a decoded code point (32 bits may be
  // out of range for UTF-32 input) and the end markers.
  typedef struct packed {
    logic [31:0] cp;
    logic        bad;
    logic        run_last;
    logic        string_end;
  } cp_item_t;

  function automatic logic cp_valid(input logic [31:0] cp);
    logic ok;
    ok = 1'b1;
    if (cp > 32'h10FFFF) ok = 1'b0;
    if (cp >= 32'hD800 && cp <= 32'hDFFF) ok = 1'b0;
    if (cp >= 32'hFDD0 && cp <= 32'hFDEF) ok = 1'b0;
    if (cp == 32'hFFFE || cp == 32'hFFFF) ok = 1'b0;
    return ok;
  endfunction

  function automatic logic is_cont(input logic [15:0] u);
    return u[7:6] == 2'b10;
  endfunction

endpackage

// File: rtl/utft_front.sv
// Front end: holds pending source units and decides one code point a cycle while the queue is not full.
// Depends on utft_pkg; feeds utft_queue.
module utft_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         src_fmt,
  input  logic               flush,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_code_unit,
  input  logic               in_last_unit,
  output logic               q_valid,
  input  logic               q_full,
  output utft_pkg::cp_item_t q_item
);

  // Working window: up to three pending units plus the current unit.
  logic [31:0] w_r [4];
  logic [31:0] w_nxt [4];
  logic [2:0]  n_r, n_nxt;
  logic        busy_r, busy_nxt;
  logic        fin_r, fin_nxt;
  logic [15:0] pend_r [3];
  logic [1:0]  pcnt_r, pcnt_nxt;

  logic        decided;
  logic        bad;
  logic [31:0] cp;
  logic [2:0]  len;
  logic [2:0]  need;
  logic [7:0]  b0;
  logic [15:0] u, l;
  logic        lead_bad;
  logic        cont_bad;
  logic        emit;
  logic        done;
  logic [31:0] unit_m;
  logic [31:0] rest [3];
  logic [2:0]  rest_n;
  logic [2:0]  rneed;
  logic        partial;

  always_comb begin
    unit_m = in_code_unit;
    unique case (src_fmt)
      utft_pkg::FMT_UTF8:  unit_m = {24'd0, in_code_unit[7:0]};
      utft_pkg::FMT_UTF16: unit_m = {16'd0, in_code_unit[15:0]};
      default:             unit_m = in_code_unit;
    endcase
  end

  always_comb begin
    decided  = 1'b1;
    bad      = 1'b0;
    cp       = 32'd0;
    len      = 3'd1;
    need     = 3'd1;
    b0       = w_r[0][7:0];
    u        = w_r[0][15:0];
    l        = w_r[1][15:0];
    lead_bad = 1'b0;
    cont_bad = 1'b0;
    unique case (src_fmt)
      utft_pkg::FMT_UTF8: begin
        if (b0[7] == 1'b0) need = 3'd1;
        else if (b0[7:5] == 3'b110) need = 3'd2;
        else if (b0[7:4] == 4'b1110) need = 3'd3;
        else if (b0[7:3] == 5'b11110) need = 3'd4;
        else lead_bad = 1'b1;
        if (n_r > 3'd1 && need > 3'd1 && !utft_pkg::is_cont(w_r[1][15:0])) cont_bad = 1'b1;
        if (n_r > 3'd2 && need > 3'd2 && !utft_pkg::is_cont(w_r[2][15:0])) cont_bad = 1'b1;
        if (n_r > 3'd3 && need > 3'd3 && !utft_pkg::is_cont(w_r[3][15:0])) cont_bad = 1'b1;
        if (lead_bad || cont_bad) begin
          bad = 1'b1;
        end else if (n_r < need) begin
          if (fin_r) bad = 1'b1;
          else decided = 1'b0;
        end else begin
          len = need;
          unique case (need)
            3'd1: cp = {24'd0, b0};
            3'd2: cp = {21'd0, b0[4:0], w_r[1][5:0]};
            3'd3: cp = {16'd0, b0[3:0], w_r[1][5:0], w_r[2][5:0]};
            default: cp = {11'd0, b0[2:0], w_r[1][5:0], w_r[2][5:0], w_r[3][5:0]};
          endcase
        end
      end
      utft_pkg::FMT_UTF16: begin
        if (u == 16'hFFFE || u == 16'hFFFF) begin
          bad = 1'b1;
        end else if (u < 16'hD800 || u > 16'hDBFF) begin
          cp = {16'd0, u};
        end else if (n_r < 3'd2) begin
          if (fin_r) bad = 1'b1;
          else decided = 1'b0;
        end else if (l < 16'hDC00 || l > 16'hDFFF) begin
          bad = 1'b1;
        end else begin
          cp  = {12'd0, u[9:0], l[9:0]} + 32'h10000;
          len = 3'd2;
        end
      end
      default: cp = w_r[0];
    endcase
  end

  // Window as it stands once the front code point has been taken off.
  always_comb begin
    for (int i = 0; i < 3; i++) rest[i] = w_r[i + 1];
    if (len == 3'd2) begin
      for (int i = 0; i < 2; i++) rest[i] = w_r[i + 2];
    end else if (len == 3'd3) begin
      rest[0] = w_r[3];
    end
  end

  // The remaining units only start a sequence that is not yet complete.
  always_comb begin
    rest_n  = n_r - len;
    partial = 1'b0;
    rneed   = 3'd1;
    unique case (src_fmt)
      utft_pkg::FMT_UTF8: begin
        if (rest[0][7:5] == 3'b110) rneed = 3'd2;
        else if (rest[0][7:4] == 4'b1110) rneed = 3'd3;
        else if (rest[0][7:3] == 5'b11110) rneed = 3'd4;
        if (rest_n != 3'd0 && rest_n < rneed) begin
          partial = 1'b1;
          if (rest_n > 3'd1 && !utft_pkg::is_cont(rest[1][15:0])) partial = 1'b0;
          if (rest_n > 3'd2 && !utft_pkg::is_cont(rest[2][15:0])) partial = 1'b0;
        end
      end
      utft_pkg::FMT_UTF16: begin
        if (rest_n == 3'd1 && rest[0][15:10] == 6'b110110) partial = 1'b1;
      end
      default: partial = 1'b0;
    endcase
  end

  assign emit = busy_r && (n_r != 3'd0) && decided && !q_full;
  // Work on the item finishes when no units are left or the front units cannot be decided yet.
  assign done = busy_r && ((n_r == 3'd0) || (!decided));
  assign in_stall = busy_r;

  always_comb begin
    q_valid = 1'b0;
    q_item  = '0;
    if (busy_r && n_r != 3'd0 && decided) begin
      q_valid           = 1'b1;
      q_item.cp         = cp;
      q_item.bad        = bad;
      q_item.run_last   = (len == n_r) || (!fin_r && partial);
      q_item.string_end = (len == n_r) && fin_r;
    end
  end

  always_comb begin
    w_nxt    = w_r;
    n_nxt    = n_r;
    busy_nxt = busy_r;
    fin_nxt  = fin_r;
    pcnt_nxt = pcnt_r;
    if (!busy_r && in_valid) begin
      for (int i = 0; i < 3; i++) w_nxt[i] = {16'd0, pend_r[i]};
      w_nxt[pcnt_r] = unit_m;
      n_nxt    = {1'b0, pcnt_r} + 3'd1;
      busy_nxt = 1'b1;
      fin_nxt  = in_last_unit;
    end else if (emit) begin
      for (int i = 0; i < 3; i++) w_nxt[i] = rest[i];
      n_nxt = n_r - len;
    end else if (done) begin
      busy_nxt = 1'b0;
      pcnt_nxt = n_r[1:0];
    end
    if (flush) pcnt_nxt = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pcnt_r <= 2'd0;
      n_r    <= 3'd0;
      fin_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      pcnt_r <= pcnt_nxt;
      n_r    <= n_nxt;
      fin_r  <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    if (done) begin
      for (int i = 0; i < 3; i++) pend_r[i] <= w_r[i][15:0];
    end
  end

endmodule

// File: rtl/utft_queue.sv
// Short queue of decided code points between the front and back ends.
// Depends on utft_pkg.
module utft_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  utft_pkg::cp_item_t wr_item,
  output logic               full,
  output logic               rd_valid,
  input  logic               rd_en,
  output utft_pkg::cp_item_t rd_item
);

  localparam int AW = $clog2(utft_pkg::QDEPTH);

  utft_pkg::cp_item_t mem_r [utft_pkg::QDEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full     = cnt_r == (AW + 1)'(utft_pkg::QDEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_item  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW + 1)'(wr_en) - (AW + 1)'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_item;
  end

endmodule

// File: rtl/utft_back.sv
// Back end: replaces invalid code points and emits target code units.
// Depends on utft_pkg; reads from utft_queue.
module utft_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         tgt_fmt,
  input  logic [20:0]        repl,
  input  logic               q_valid,
  output logic               q_rd,
  input  utft_pkg::cp_item_t q_item,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_out_unit,
  output logic               out_run_last,
  output logic               out_string_end
);

  logic [31:0] cp;
  logic [2:0]  nunits;
  logic [31:0] units [4];
  logic [31:0] v;
  logic [1:0]  idx_r, idx_nxt;
  logic        last_unit;
  logic        vld_r;
  logic [31:0] ou_r;
  logic        rl_r, se_r;
  logic        slot_free;

  always_comb begin
    cp = (q_item.bad || !utft_pkg::cp_valid(q_item.cp)) ? {11'd0, repl} : q_item.cp;
    v  = cp - 32'h10000;
    units[0] = cp;
    units[1] = 32'd0;
    units[2] = 32'd0;
    units[3] = 32'd0;
    nunits   = 3'd1;
    unique case (tgt_fmt)
      utft_pkg::FMT_UTF8: begin
        if (cp <= 32'h7F) begin
          units[0] = cp;
        end else if (cp <= 32'h7FF) begin
          units[0] = {24'd0, 3'b110, cp[10:6]};
          units[1] = {24'd0, 2'b10, cp[5:0]};
          nunits   = 3'd2;
        end else if (cp <= 32'hFFFF) begin
          units[0] = {24'd0, 4'b1110, cp[15:12]};
          units[1] = {24'd0, 2'b10, cp[11:6]};
          units[2] = {24'd0, 2'b10, cp[5:0]};
          nunits   = 3'd3;
        end else begin
          units[0] = {24'd0, 5'b11110, cp[20:18]};
          units[1] = {24'd0, 2'b10, cp[17:12]};
          units[2] = {24'd0, 2'b10, cp[11:6]};
          units[3] = {24'd0, 2'b10, cp[5:0]};
          nunits   = 3'd4;
        end
      end
      utft_pkg::FMT_UTF16: begin
        if (cp >= 32'h10000) begin
          units[0] = {16'd0, 6'b110110, v[19:10]};
          units[1] = {16'd0, 6'b110111, v[9:0]};
          nunits   = 3'd2;
        end
      end
      default: units[0] = cp;
    endcase
  end

  assign slot_free = !vld_r || !out_stall;
  assign last_unit = ({1'b0, idx_r} + 3'd1) == nunits;
  assign q_rd      = q_valid && slot_free && last_unit;

  always_comb begin
    idx_nxt = idx_r;
    if (q_valid && slot_free) idx_nxt = last_unit ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
      if (slot_free) vld_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && slot_free) begin
      ou_r <= units[idx_r];
      rl_r <= last_unit && q_item.run_last;
      se_r <= last_unit && q_item.string_end;
    end
  end

  assign out_valid      = vld_r;
  assign out_out_unit   = ou_r;
  assign out_run_last   = rl_r;
  assign out_string_end = se_r;

endmodule

// File: rtl/utf_transcoder_top.sv
// Top level of the UTF-8/16/32 transcoder: configuration registers and the
// front end, queue and back end. Depends on utft_pkg and all utft_ modules.
//
//   channel | ports                                         | direction
//   input   | in_valid, in_stall, in_code_unit, in_last_unit | in
//   result  | out_valid, out_stall, out_out_unit, out_run_last, out_string_end | out
//   config  | cfg_we, cfg_index, cfg_data                    | in
//
// The front end takes one input transaction, then decides one code point a
// cycle from its four-unit window while the queue has room, then closes the item.
// The back end emits one target unit a cycle unless out_stall holds it, up to four per code point.
// Reset is synchronous and active low; the pending buffer starts empty.
// Either side stalls on its own through the four-entry code point queue.
module utf_transcoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [20:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_code_unit,
  input  logic        in_last_unit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_out_unit,
  output logic        out_run_last,
  output logic        out_string_end
);

  logic [1:0]  src_r, tgt_r;
  logic [20:0] repl_r;
  logic        flush;

  logic               fq_valid, q_full, q_valid, q_rd;
  utft_pkg::cp_item_t fq_item, q_item;

  assign flush = cfg_we && cfg_index == utft_pkg::CFG_SOURCE_FORMAT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r  <= utft_pkg::FMT_UTF8;
      tgt_r  <= utft_pkg::FMT_UTF16;
      repl_r <= 21'h00FFFD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        utft_pkg::CFG_SOURCE_FORMAT:    src_r  <= cfg_data[1:0];
        utft_pkg::CFG_TARGET_FORMAT:    tgt_r  <= cfg_data[1:0];
        utft_pkg::CFG_REPLACEMENT_CODE: repl_r <= cfg_data;
        default: ;
      endcase
    end
  end

  utft_front u_front (
    .clk, .rst_n, .src_fmt(src_r), .flush,
    .in_valid, .in_stall, .in_code_unit, .in_last_unit,
    .q_valid(fq_valid), .q_full, .q_item(fq_item)
  );

  utft_queue u_queue (
    .clk, .rst_n, .wr_en(fq_valid && !q_full), .wr_item(fq_item), .full(q_full),
    .rd_valid(q_valid), .rd_en(q_rd), .rd_item(q_item)
  );

  utft_back u_back (
    .clk, .rst_n, .tgt_fmt(tgt_r), .repl(repl_r),
    .q_valid, .q_rd, .q_item,
    .out_valid, .out_stall, .out_out_unit, .out_run_last, .out_string_end
  );

endmodule
